// ===== rtl/dpr_pkg.sv =====
// Shared types and constants for the dive phase recorder sequencer.
package dpr_pkg;

  localparam int DEPTH_W        = 20;
  localparam int THR_W          = 19;
  localparam int RING_DEPTH_DEF = 7;

  localparam logic [THR_W-1:0] POWER_ON_RST  = THR_W'(5000);
  localparam logic [THR_W-1:0] POWER_OFF_RST = THR_W'(4000);
  localparam logic [THR_W-1:0] SURFACE_RST   = THR_W'(2000);
  localparam logic [THR_W-1:0] JUMP_RST      = THR_W'(10000);

  typedef enum logic [1:0] {
    REG_POWER_ON  = 2'd0,
    REG_POWER_OFF = 2'd1,
    REG_SURFACE   = 2'd2,
    REG_JUMP      = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    CODE_ACCEPT = 2'd0,
    CODE_ZERO   = 2'd1,
    CODE_REPEAT = 2'd2,
    CODE_JUMP   = 2'd3
  } sample_code_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_POWER_ON  = 3'd1,
    ACT_POWER_OFF = 3'd2,
    ACT_BOTTOM    = 3'd3,
    ACT_DIVE_END  = 3'd4,
    ACT_NEW_DIVE  = 3'd5
  } action_t;

  typedef struct packed {
    logic [THR_W-1:0] power_on;
    logic [THR_W-1:0] power_off;
    logic [THR_W-1:0] surface;
  } thr_cfg_t;

  typedef struct packed {
    logic [2:0]                status;
    action_t                   act;
    logic                      power;
    logic                      surface;
    logic signed [DEPTH_W-1:0] deepest;
  } seq_out_t;

  typedef struct packed {
    sample_code_t              code;
    seq_out_t                  seq;
  } result_t;

endpackage

// ===== rtl/dpr_cell.sv =====
// One cell of the depth history line: holds a sample and hands it on.
module dpr_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               shift,
  input  logic signed [dpr_pkg::DEPTH_W-1:0] din,
  output logic signed [dpr_pkg::DEPTH_W-1:0] dout
);

  logic signed [dpr_pkg::DEPTH_W-1:0] val;

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else if (shift) begin
      val <= din;
    end
  end

  assign dout = val;

endmodule

// ===== rtl/dpr_seq.sv =====
// Dive status sequencer: status, recorder power, surface flag, max depth.
module dpr_seq #(
  parameter int DIR_W = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic                               step,
  input  logic signed [dpr_pkg::DEPTH_W-1:0] depth,
  input  logic signed [dpr_pkg::DEPTH_W-1:0] prev,
  input  logic signed [DIR_W-1:0]            dir,
  input  dpr_pkg::thr_cfg_t                  cfg,
  output dpr_pkg::seq_out_t                  seq_next
);

  typedef enum logic [2:0] {
    ST_INIT         = 3'd0,
    ST_READY        = 3'd1,
    ST_DESCEND      = 3'd2,
    ST_DEEP         = 3'd3,
    ST_ASCEND       = 3'd4,
    ST_NEAR_SURFACE = 3'd5,
    ST_SURFACED     = 3'd6
  } status_t;

  status_t                            status, status_next;
  logic                               power, power_next;
  logic                               surface, surface_next;
  logic signed [dpr_pkg::DEPTH_W-1:0] deepest, deepest_next;
  dpr_pkg::action_t                   act;
  logic signed [dpr_pkg::DEPTH_W-1:0] on_s, off_s, surf_s;
  logic                               dir_pos, dir_neg;

  assign on_s    = {1'b0, cfg.power_on};
  assign off_s   = {1'b0, cfg.power_off};
  assign surf_s  = {1'b0, cfg.surface};
  assign dir_neg = dir[DIR_W-1];
  assign dir_pos = !dir[DIR_W-1] && (dir != '0);

  always_comb begin
    status_next  = status;
    power_next   = power;
    surface_next = surface;
    act          = dpr_pkg::ACT_NONE;
    deepest_next = (take && (depth > prev)) ? depth : deepest;
    if (step) begin
      case (status)
        ST_INIT, ST_READY: begin
          status_next = ST_READY;
          if (dir_pos) begin
            if (prev > on_s) begin
              surface_next = 1'b0;
              status_next  = ST_DESCEND;
            end
          end else if (prev > off_s) begin
            surface_next = 1'b0;
            status_next  = ST_DESCEND;
          end else if (prev < surf_s) begin
            surface_next = 1'b1;
            status_next  = ST_NEAR_SURFACE;
          end
        end
        ST_DESCEND: begin
          if (dir_pos) begin
            if (prev > on_s) begin
              power_next  = 1'b1;
              act         = dpr_pkg::ACT_POWER_ON;
              status_next = ST_DEEP;
            end
          end else if (prev >= off_s) begin
            power_next  = 1'b1;
            act         = dpr_pkg::ACT_POWER_ON;
            status_next = ST_ASCEND;
          end else begin
            act         = power ? dpr_pkg::ACT_POWER_OFF : dpr_pkg::ACT_NONE;
            power_next  = 1'b0;
            status_next = ST_NEAR_SURFACE;
          end
        end
        ST_DEEP: begin
          if (dir_neg) begin
            status_next = ST_ASCEND;
            act         = dpr_pkg::ACT_BOTTOM;
          end
        end
        ST_ASCEND: begin
          if (dir_pos) begin
            deepest_next = depth;
            status_next  = ST_DEEP;
          end else if (prev < off_s) begin
            status_next = ST_NEAR_SURFACE;
            act         = power ? dpr_pkg::ACT_POWER_OFF : dpr_pkg::ACT_NONE;
            power_next  = 1'b0;
          end
        end
        ST_NEAR_SURFACE: begin
          if (dir_neg && (prev < surf_s)) begin
            status_next  = ST_SURFACED;
            surface_next = 1'b1;
            act          = dpr_pkg::ACT_DIVE_END;
          end
        end
        ST_SURFACED: begin
          if (dir_pos) begin
            status_next = ST_READY;
            act         = dpr_pkg::ACT_NEW_DIVE;
          end else if (prev > off_s) begin
            status_next = ST_READY;
          end
        end
        default: begin
          status_next = ST_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status  <= ST_INIT;
      power   <= 1'b0;
      surface <= 1'b1;
      deepest <= '0;
    end else begin
      status  <= status_next;
      power   <= power_next;
      surface <= surface_next;
      deepest <= deepest_next;
    end
  end

  assign seq_next.status  = status_next;
  assign seq_next.act     = act;
  assign seq_next.power   = power_next;
  assign seq_next.surface = surface_next;
  assign seq_next.deepest = deepest_next;

endmodule

// ===== rtl/dive_phase_recorder_sequencer.sv =====
// Top level of the dive phase recorder sequencer.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | depth_cm
//   out     | output    | out_valid / out_stall| sample_code .. max_depth_cm
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One depth sample is accepted per cycle while in_stall is low. Its result
// enters the output register, or a skid register holding one extra result
// while the output is stalled; in_stall rises only when the skid register is
// full. The running ring sum and the sequencer settle in the accepting
// cycle, so samples follow back to back. Reset loads the register defaults,
// clears the history line, and leaves the recorder off and surfaced.
module dive_phase_recorder_sequencer #(
  parameter int RING_DEPTH = dpr_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [dpr_pkg::DEPTH_W-1:0] depth_cm,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         sample_code,
  output logic [2:0]                         dive_status,
  output logic [2:0]                         action,
  output logic                               recorder_on,
  output logic                               at_surface,
  output logic signed [dpr_pkg::DEPTH_W-1:0] max_depth_cm,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [dpr_pkg::THR_W-1:0]          cfg_data
);

  localparam int DW     = dpr_pkg::DEPTH_W;
  localparam int SUM_W  = DW + $clog2(RING_DEPTH);
  localparam int DIR_W  = SUM_W + 1;
  localparam int WARM_W = $clog2(RING_DEPTH + 1);
  localparam logic signed [DIR_W-1:0] RD_S = DIR_W'(RING_DEPTH);

  logic [dpr_pkg::THR_W-1:0] power_on_depth, power_off_depth, surface_depth, jump_limit;
  dpr_pkg::thr_cfg_t         cfg;

  logic signed [DW-1:0]     last_depth;
  logic signed [SUM_W-1:0]  ring_sum, ring_sum_next;
  logic [WARM_W-1:0]        warm_count;
  logic signed [DW-1:0]     tap [RING_DEPTH];
  logic signed [DW:0]       diff;
  logic [DW:0]              adiff;
  dpr_pkg::sample_code_t    code;
  logic                     accept, take, step;
  logic signed [DIR_W-1:0]  dir;
  dpr_pkg::seq_out_t        seq_next;
  dpr_pkg::result_t         res_new, out_reg, skid_reg;
  logic                     skid_valid, out_xfer;

  assign cfg_ready = 1'b1;
  assign cfg.power_on  = power_on_depth;
  assign cfg.power_off = power_off_depth;
  assign cfg.surface   = surface_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      power_on_depth  <= dpr_pkg::POWER_ON_RST;
      power_off_depth <= dpr_pkg::POWER_OFF_RST;
      surface_depth   <= dpr_pkg::SURFACE_RST;
      jump_limit      <= dpr_pkg::JUMP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (dpr_pkg::reg_index_t'(cfg_index))
        dpr_pkg::REG_POWER_ON:  power_on_depth  <= cfg_data;
        dpr_pkg::REG_POWER_OFF: power_off_depth <= cfg_data;
        dpr_pkg::REG_SURFACE:   surface_depth   <= cfg_data;
        dpr_pkg::REG_JUMP:      jump_limit      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;
  assign diff   = {depth_cm[DW-1], depth_cm} - {last_depth[DW-1], last_depth};
  assign adiff  = diff[DW] ? $unsigned(-diff) : $unsigned(diff);

  always_comb begin
    if (depth_cm == '0) begin
      code = dpr_pkg::CODE_ZERO;
    end else if (depth_cm == last_depth) begin
      code = dpr_pkg::CODE_REPEAT;
    end else if (adiff > {2'b00, jump_limit}) begin
      code = dpr_pkg::CODE_JUMP;
    end else begin
      code = dpr_pkg::CODE_ACCEPT;
    end
  end

  assign take = accept && (code == dpr_pkg::CODE_ACCEPT);
  assign step = take && (warm_count >= WARM_W'(RING_DEPTH - 1));

  genvar gi;
  generate
    for (gi = 0; gi < RING_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        dpr_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (take),
          .din   (depth_cm),
          .dout  (tap[gi])
        );
      end else begin : g_body
        dpr_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (take),
          .din   (tap[gi-1]),
          .dout  (tap[gi])
        );
      end
    end
  endgenerate

  assign ring_sum_next = ring_sum - SUM_W'(tap[RING_DEPTH-1]) + SUM_W'(depth_cm);
  assign dir = DIR_W'(RD_S * DIR_W'(depth_cm)) - DIR_W'(ring_sum_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_depth <= '0;
      ring_sum   <= '0;
      warm_count <= '0;
    end else if (take) begin
      last_depth <= depth_cm;
      ring_sum   <= ring_sum_next;
      if (warm_count < WARM_W'(RING_DEPTH)) begin
        warm_count <= warm_count + WARM_W'(1);
      end
    end
  end

  dpr_seq #(
    .DIR_W (DIR_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .step     (step),
    .depth    (depth_cm),
    .prev     (last_depth),
    .dir      (dir),
    .cfg      (cfg),
    .seq_next (seq_next)
  );

  assign res_new.code = code;
  assign res_new.seq  = seq_next;

  assign out_xfer = out_valid && !out_stall;
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !out_xfer) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (out_valid && !out_xfer) begin
        skid_reg <= res_new;
      end else begin
        out_reg <= res_new;
      end
    end
  end

  assign sample_code  = out_reg.code;
  assign dive_status  = out_reg.seq.status;
  assign action       = out_reg.seq.act;
  assign recorder_on  = out_reg.seq.power;
  assign at_surface   = out_reg.seq.surface;
  assign max_depth_cm = out_reg.seq.deepest;

endmodule

// ===== rtl/dpr_checker.sv =====
// Port-level checks on the result stream of the dive phase recorder sequencer.
module dpr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic [1:0] sample_code,
  input logic [2:0] action,
  input logic       recorder_on,
  input logic       at_surface
);

  a_reject_no_action: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sample_code != dpr_pkg::CODE_ACCEPT) |-> action == dpr_pkg::ACT_NONE)
    else $error("rejected sample carries an action");

  a_power_on: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == dpr_pkg::ACT_POWER_ON) |-> recorder_on)
    else $error("power on action with recorder off");

  a_power_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == dpr_pkg::ACT_POWER_OFF) |-> !recorder_on)
    else $error("power off action with recorder on");

  a_dive_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action == dpr_pkg::ACT_DIVE_END) |-> at_surface)
    else $error("dive end without surface flag");

endmodule

bind dive_phase_recorder_sequencer dpr_checker u_dpr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .sample_code (sample_code),
  .action      (action),
  .recorder_on (recorder_on),
  .at_surface  (at_surface)
);

// ===== sim/dive_phase_recorder_sequencer_tb.sv =====
// Testbench for the dive sequencer: predicts each sample report and checks the output stream.
module dive_phase_recorder_sequencer_tb;

  localparam int RING = dpr_pkg::RING_DEPTH_DEF;
  localparam int DEPTH_W = dpr_pkg::DEPTH_W;
  localparam int THR_W = dpr_pkg::THR_W;
  localparam int N_DIRECTED = 24;

  typedef enum logic [2:0] {
    S_INIT         = 3'd0,
    S_READY        = 3'd1,
    S_DESCEND      = 3'd2,
    S_DEEP         = 3'd3,
    S_ASCEND       = 3'd4,
    S_NEAR_SURFACE = 3'd5,
    S_SURFACED     = 3'd6
  } dive_status_t;

  typedef struct {
    dpr_pkg::sample_code_t     code;
    logic [2:0]                status;
    dpr_pkg::action_t          act;
    logic                      rec;
    logic                      surf;
    logic signed [DEPTH_W-1:0] max_d;
  } dive_report_t;

  class dive_tracker;
    longint       depth_ring [RING];
    longint       ring_sum, last_d, prev_d, max_d;
    int           ring_pos, warm;
    dive_status_t status;
    logic         power, surfaced;
    longint       on_thr, off_thr, surf_thr, jump_thr;
    dive_report_t pending_reports [$];
    int           errors;

    function new();
      foreach (depth_ring[i]) depth_ring[i] = 0;
      ring_sum = 0;
      last_d = 0;
      prev_d = 0;
      max_d = 0;
      ring_pos = 0;
      warm = 0;
      status = S_INIT;
      power = 1'b0;
      surfaced = 1'b1;
      on_thr = dpr_pkg::POWER_ON_RST;
      off_thr = dpr_pkg::POWER_OFF_RST;
      surf_thr = dpr_pkg::SURFACE_RST;
      jump_thr = dpr_pkg::JUMP_RST;
      errors = 0;
    endfunction

    function void set_reg(dpr_pkg::reg_index_t idx, logic [THR_W-1:0] value);
      case (idx)
        dpr_pkg::REG_POWER_ON:  on_thr = value;
        dpr_pkg::REG_POWER_OFF: off_thr = value;
        dpr_pkg::REG_SURFACE:   surf_thr = value;
        dpr_pkg::REG_JUMP:      jump_thr = value;
        default: ;
      endcase
    endfunction

    function dpr_pkg::action_t power_down();
      if (power) begin
        power = 1'b0;
        return dpr_pkg::ACT_POWER_OFF;
      end
      return dpr_pkg::ACT_NONE;
    endfunction

    function dpr_pkg::action_t advance(longint dir);
      dpr_pkg::action_t act;
      act = dpr_pkg::ACT_NONE;
      case (status)
        S_INIT, S_READY: begin
          status = S_READY;
          if (dir > 0) begin
            if (prev_d > on_thr) begin
              surfaced = 1'b0;
              status = S_DESCEND;
            end
          end else if (prev_d > off_thr) begin
            surfaced = 1'b0;
            status = S_DESCEND;
          end else if (prev_d < surf_thr) begin
            surfaced = 1'b1;
            status = S_NEAR_SURFACE;
          end
        end
        S_DESCEND: begin
          if (dir > 0) begin
            if (prev_d > on_thr) begin
              power = 1'b1;
              act = dpr_pkg::ACT_POWER_ON;
              status = S_DEEP;
            end
          end else if (prev_d >= off_thr) begin
            power = 1'b1;
            act = dpr_pkg::ACT_POWER_ON;
            status = S_ASCEND;
          end else begin
            act = power_down();
            status = S_NEAR_SURFACE;
          end
        end
        S_DEEP: begin
          if (dir < 0) begin
            status = S_ASCEND;
            act = dpr_pkg::ACT_BOTTOM;
          end
        end
        S_ASCEND: begin
          if (dir > 0) begin
            max_d = last_d;
            status = S_DEEP;
          end else if (prev_d < off_thr) begin
            status = S_NEAR_SURFACE;
            act = power_down();
          end
        end
        S_NEAR_SURFACE: begin
          if (dir < 0 && prev_d < surf_thr) begin
            status = S_SURFACED;
            surfaced = 1'b1;
            act = dpr_pkg::ACT_DIVE_END;
          end
        end
        S_SURFACED: begin
          if (dir > 0) begin
            status = S_READY;
            act = dpr_pkg::ACT_NEW_DIVE;
          end else if (prev_d > off_thr) begin
            status = S_READY;
          end
        end
        default: status = S_INIT;
      endcase
      return act;
    endfunction

    function void log_sample(logic signed [DEPTH_W-1:0] depth);
      dive_report_t rep;
      longint d, delta;
      d = depth;
      delta = (d > last_d) ? d - last_d : last_d - d;
      rep.act = dpr_pkg::ACT_NONE;
      if (d == 0) rep.code = dpr_pkg::CODE_ZERO;
      else if (d == last_d) rep.code = dpr_pkg::CODE_REPEAT;
      else if (delta > jump_thr) rep.code = dpr_pkg::CODE_JUMP;
      else rep.code = dpr_pkg::CODE_ACCEPT;
      if (rep.code == dpr_pkg::CODE_ACCEPT) begin
        prev_d = last_d;
        last_d = d;
        if (last_d > prev_d) max_d = last_d;
        ring_sum = ring_sum - depth_ring[ring_pos] + d;
        depth_ring[ring_pos] = d;
        ring_pos = (ring_pos + 1) % RING;
        if (warm < RING) warm++;
        if (warm >= RING) rep.act = advance(RING * d - ring_sum);
      end
      rep.status = status;
      rep.rec = power;
      rep.surf = surfaced;
      rep.max_d = max_d[DEPTH_W-1:0];
      pending_reports.push_back(rep);
    endfunction

    function void check_report(dive_report_t got);
      dive_report_t want;
      if (pending_reports.size() == 0) begin
        $error("report with no pending sample: code %0d status %0d action %0d",
               got.code, got.status, got.act);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.code !== want.code) begin
        $error("sample_code: expected %0d, got %0d", want.code, got.code);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("dive_status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.act !== want.act) begin
        $error("action: expected %0d, got %0d", want.act, got.act);
        errors++;
      end
      if (got.rec !== want.rec) begin
        $error("recorder_on: expected %0d, got %0d", want.rec, got.rec);
        errors++;
      end
      if (got.surf !== want.surf) begin
        $error("at_surface: expected %0d, got %0d", want.surf, got.surf);
        errors++;
      end
      if (got.max_d !== want.max_d) begin
        $error("max_depth_cm: expected %0d, got %0d", want.max_d, got.max_d);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [DEPTH_W-1:0] depth_cm;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                sample_code;
  logic [2:0]                dive_status;
  logic [2:0]                action;
  logic                      recorder_on;
  logic                      at_surface;
  logic signed [DEPTH_W-1:0] max_depth_cm;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [THR_W-1:0]          cfg_data;

  dive_tracker  tracker;
  dive_report_t seen;
  bit           in_calm;
  int           fed_depths;

  int directed_depths [N_DIRECTED] = '{
    20000, 0, -10000, -10000, 524287, -524288, -2000, 3000, 6000, 9000, 12000, 15000,
    18000, 20000, 19000, 22000, 15000, 8000, 3000, 1000, 500, 600, 300000, 700
  };

  dive_phase_recorder_sequencer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .depth_cm     (depth_cm),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_code  (sample_code),
    .dive_status  (dive_status),
    .action       (action),
    .recorder_on  (recorder_on),
    .at_surface   (at_surface),
    .max_depth_cm (max_depth_cm),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_depth(input int d);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    depth_cm <= d[DEPTH_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.log_sample(d[DEPTH_W-1:0]);
    fed_depths++;
  endtask

  task automatic write_reg(input dpr_pkg::reg_index_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[THR_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, value[THR_W-1:0]);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_thresholds(input int on_cm, input int off_cm, input int surf_cm,
                                 input int jump_cm);
    write_reg(dpr_pkg::REG_POWER_ON, on_cm);
    write_reg(dpr_pkg::REG_POWER_OFF, off_cm);
    write_reg(dpr_pkg::REG_SURFACE, surf_cm);
    write_reg(dpr_pkg::REG_JUMP, jump_cm);
  endtask

  // drop valid and drain every pending report
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_noise();
    int d;
    case ($urandom_range(0, 4))
      0: d = 0;
      1: d = int'(tracker.last_d);
      2: begin
        if ($urandom_range(0, 1) == 0)
          d = int'(tracker.last_d) + int'(tracker.jump_thr) + int'($urandom_range(1, 5000));
        else
          d = int'(tracker.last_d) - int'(tracker.jump_thr) - int'($urandom_range(1, 5000));
      end
      3: d = int'($urandom_range(0, 310000)) - 10000;
      default: d = int'($urandom_range(0, 20'hFFFFF));
    endcase
    send_depth(d);
  endtask

  // descend to a bottom, wander there, climb back with a few reversals, linger on top
  task automatic run_dive();
    int bottom, top, smax, d, guard;
    if ($urandom_range(0, 6) == 0) bottom = $urandom_range(100000, 300000);
    else bottom = $urandom_range(3000, 40000);
    top = int'($urandom_range(0, 2000)) - 300;
    smax = bottom / 8 + 200;
    if (smax > tracker.jump_thr) smax = int'(tracker.jump_thr);
    if (smax < 1) smax = 1;
    in_calm = ($urandom_range(0, 3) == 0);
    guard = 0;
    while (tracker.last_d < bottom && guard < 200) begin
      d = int'(tracker.last_d) + int'($urandom_range(1, smax));
      if (d > 300000) d = 300000;
      send_depth(d);
      guard++;
    end
    repeat ($urandom_range(1, 4))
      send_depth(int'(tracker.last_d) + int'($urandom_range(0, 2 * smax)) - smax);
    guard = 0;
    while (tracker.last_d > top && guard < 200) begin
      if ($urandom_range(0, 7) == 0) d = int'(tracker.last_d) + int'($urandom_range(1, smax));
      else d = int'(tracker.last_d) - int'($urandom_range(1, smax));
      if (d < -10000) d = -10000;
      send_depth(d);
      guard++;
    end
    repeat ($urandom_range(2, 6))
      send_depth(int'(tracker.last_d) + int'($urandom_range(0, 600)) - 300);
    in_calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.code = dpr_pkg::sample_code_t'(sample_code);
      seen.status = dive_status;
      seen.act = dpr_pkg::action_t'(action);
      seen.rec = recorder_on;
      seen.surf = at_surface;
      seen.max_d = max_depth_cm;
      tracker.check_report(seen);
    end
  end

  initial begin
    int free_run, hold;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 9) == 0) free_run = $urandom_range(30, 120);
      else free_run = $urandom_range(0, 4);
      hold = pick_gap();
      repeat (free_run) @(negedge clk);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        @(negedge clk);
      end
    end
  end

  initial begin
    #(12 * 2000000);
    $display("FAIL dive_phase_recorder_sequencer");
    $finish;
  end

  initial begin
    int on_cm, off_cm, surf_cm, jump_cm, quota, start;
    tracker = new();
    rst = 1'b1;
    in_valid = 1'b0;
    depth_cm = '0;
    cfg_valid = 1'b0;
    cfg_index = dpr_pkg::REG_POWER_ON;
    cfg_data = '0;
    in_calm = 1'b0;
    fed_depths = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_depths[i]) send_depth(directed_depths[i]);
    settle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin
          on_cm = 5000;
          off_cm = 4000;
          surf_cm = 2000;
          jump_cm = 10000;
        end
        1: begin
          on_cm = 0;
          off_cm = 0;
          surf_cm = 0;
          jump_cm = 0;
        end
        2: begin
          on_cm = 19'h7FFFF;
          off_cm = 19'h7FFFF;
          surf_cm = 19'h7FFFF;
          jump_cm = 19'h7FFFF;
        end
        3: begin
          on_cm = 0;
          off_cm = 0;
          surf_cm = 0;
          jump_cm = 300000;
        end
        default: begin
          on_cm = $urandom_range(500, 30000);
          off_cm = $urandom_range(0, on_cm);
          surf_cm = $urandom_range(0, off_cm);
          jump_cm = (p == 6) ? 300000 : $urandom_range(1000, 300000);
        end
      endcase
      load_thresholds(on_cm, off_cm, surf_cm, jump_cm);
      quota = (jump_cm == 0) ? 30 : 75;
      start = fed_depths;
      while (fed_depths - start < quota) begin
        if (tracker.jump_thr == 0 || $urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4)) send_noise();
        else
          run_dive();
      end
      settle();
    end

    if (tracker.errors == 0) begin
      $display("PASS dive_phase_recorder_sequencer");
    end else begin
      $display("FAIL dive_phase_recorder_sequencer");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/dpr_pkg.sv
rtl/dpr_cell.sv
rtl/dpr_seq.sv
rtl/dive_phase_recorder_sequencer.sv
rtl/dpr_checker.sv
sim/dive_phase_recorder_sequencer_tb.sv
